// File: sv/v7u8_pkg.sv
// Shared types, constants and UTF-8 helper functions of the VLQ-7 to UTF-8 transcoder.
package v7u8_pkg;

    localparam int unsigned CP_W                = 21;
    localparam int unsigned LIMIT_W             = 16;
    localparam int unsigned COUNT_W             = 17;
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [CP_W-1:0]    OVF_LIMIT       = 21'h0021FF;
    localparam logic [CP_W-1:0]    SURR_LO         = 21'h00D800;
    localparam logic [CP_W-1:0]    SURR_HI         = 21'h00DFFF;
    localparam logic [CP_W-1:0]    MAX_CODE_POINT  = 21'h10FFFF;
    localparam logic [CP_W-1:0]    ONE_BYTE_END    = 21'h000080;
    localparam logic [CP_W-1:0]    TWO_BYTE_END    = 21'h000800;
    localparam logic [CP_W-1:0]    THREE_BYTE_END  = 21'h010000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_START = 2'd1,
        ST_INVALID  = 2'd2,
        ST_LIMIT    = 2'd3
    } status_t;

    // One queue entry: everything a single input word produces.
    typedef struct packed {
        logic            a_valid;   // encoded code point in a_bytes
        logic [2:0]      a_len;     // 1 to 4 bytes
        logic [3:0][7:0] a_bytes;   // a_bytes[0] goes out first
        logic            b_valid;   // trailing one-byte code point
        logic [6:0]      b_char;
        logic            s_valid;   // status-only word at the end
        status_t         s_code;
        logic            msg_end;   // last word of this entry closes the message
    } v7u8_job_t;

    function automatic logic [2:0] enc_len(input logic [CP_W-1:0] cp);
        logic [2:0] len;
        if (cp < ONE_BYTE_END)
            len = 3'd1;
        else if (cp < TWO_BYTE_END)
            len = 3'd2;
        else if (cp < THREE_BYTE_END)
            len = 3'd3;
        else
            len = 3'd4;
        return len;
    endfunction

    function automatic logic cp_legal(input logic [CP_W-1:0] cp);
        logic ok;
        ok = !(cp inside {[SURR_LO:SURR_HI]}) && (cp <= MAX_CODE_POINT);
        return ok;
    endfunction

    function automatic logic [3:0][7:0] utf8_encode(input logic [CP_W-1:0] cp,
                                                    input logic [2:0] len);
        logic [3:0][7:0] bytes;
        bytes = '0;
        case (len)
            3'd1:
            begin
                bytes[0] = {1'b0, cp[6:0]};
            end
            3'd2:
            begin
                bytes[0] = {3'b110, cp[10:6]};
                bytes[1] = {2'b10, cp[5:0]};
            end
            3'd3:
            begin
                bytes[0] = {4'b1110, cp[15:12]};
                bytes[1] = {2'b10, cp[11:6]};
                bytes[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                bytes[0] = {5'b11110, cp[20:18]};
                bytes[1] = {2'b10, cp[17:12]};
                bytes[2] = {2'b10, cp[11:6]};
                bytes[3] = {2'b10, cp[5:0]};
            end
        endcase
        return bytes;
    endfunction

endpackage

// File: sv/v7u8_front.sv
// Front end: accepts input words, tracks the message state and builds queue entries.
module v7u8_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [v7u8_pkg::LIMIT_W-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          in_byte,
    input  logic                                in_last,
    input  logic                                queue_full,
    output logic                                push,
    output v7u8_pkg::v7u8_job_t                 push_job
);
    import v7u8_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    logic [CP_W-1:0]    pending_reg, pending_next;
    logic               synced_reg, synced_next;
    logic               dropping_reg, dropping_next;
    logic [COUNT_W-1:0] emitted_reg, emitted_next;

    logic               accept, is_start;
    logic [CP_W-1:0]    shifted, cp_a;
    logic [2:0]         len_a;
    logic               legal_a;
    logic [COUNT_W:0]   sum_a, sum_b;
    logic               over_a, over_b;
    logic               flush_a, flush_b, a_ok, b_ok, err;
    status_t            st;

    assign cfg_ready = 1'b1;
    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;
    assign is_start  = !in_byte[7];

    assign shifted = {pending_reg[CP_W-8:0], in_byte[6:0]};
    assign cp_a    = !synced_reg ? {{(CP_W-7){1'b0}}, in_byte[6:0]}
                                 : (is_start ? pending_reg : shifted);
    assign len_a   = enc_len(cp_a);
    assign legal_a = cp_legal(cp_a);
    assign sum_a   = {1'b0, emitted_reg} + {{(COUNT_W-2){1'b0}}, len_a};
    assign sum_b   = sum_a + {{COUNT_W{1'b0}}, 1'b1};
    assign over_a  = sum_a > {2'b00, limit_reg};
    assign over_b  = sum_b > {2'b00, limit_reg};

    always_comb
    begin
        flush_a = 1'b0;
        flush_b = 1'b0;
        err     = 1'b0;
        st      = ST_OK;
        if (dropping_reg)
        begin
            // Everything up to the end of the message is discarded.
        end
        else if (!synced_reg)
        begin
            if (is_start)
                flush_a = in_last;
            else if (in_last)
            begin
                err = 1'b1;
                st  = ST_NO_START;
            end
        end
        else if (is_start)
        begin
            flush_a = 1'b1;
            flush_b = in_last;
        end
        else if (pending_reg > OVF_LIMIT)
        begin
            err = 1'b1;
            st  = ST_INVALID;
        end
        else
        begin
            flush_a = in_last;
        end

        a_ok = flush_a && legal_a && !over_a;
        b_ok = flush_b && a_ok && !over_b;
        if (flush_a && !legal_a)
        begin
            err = 1'b1;
            st  = ST_INVALID;
        end
        else if (flush_a && over_a)
        begin
            err = 1'b1;
            st  = ST_LIMIT;
        end
        else if (flush_b && over_b)
        begin
            err = 1'b1;
            st  = ST_LIMIT;
        end
    end

    // An error closes the message at once, even in the middle of it.
    always_comb
    begin
        push_job.a_valid = a_ok;
        push_job.a_len   = len_a;
        push_job.a_bytes = utf8_encode(cp_a, len_a);
        push_job.b_valid = b_ok;
        push_job.b_char  = in_byte[6:0];
        push_job.s_valid = err;
        push_job.s_code  = st;
        push_job.msg_end = in_last || err;
    end

    assign push = accept && !dropping_reg && (a_ok || b_ok || err);

    always_comb
    begin
        pending_next  = pending_reg;
        synced_next   = synced_reg;
        dropping_next = dropping_reg;
        emitted_next  = emitted_reg;
        if (dropping_reg)
        begin
            if (in_last)
                dropping_next = 1'b0;
        end
        else if (err || in_last)
        begin
            pending_next  = '0;
            synced_next   = 1'b0;
            emitted_next  = '0;
            dropping_next = err && !in_last;
        end
        else
        begin
            if (is_start)
            begin
                pending_next = {{(CP_W-7){1'b0}}, in_byte[6:0]};
                synced_next  = 1'b1;
            end
            else if (synced_reg)
                pending_next = shifted;
            if (a_ok)
                emitted_next = sum_a[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= LIMIT_RESET;
            pending_reg  <= '0;
            synced_reg   <= 1'b0;
            dropping_reg <= 1'b0;
            emitted_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
                limit_reg <= cfg_data;
            if (accept)
            begin
                pending_reg  <= pending_next;
                synced_reg   <= synced_next;
                dropping_reg <= dropping_next;
                emitted_reg  <= emitted_next;
            end
        end
    end

endmodule

// File: sv/v7u8_queue.sv
// Small register queue of jobs between the front and back ends.
module v7u8_queue #(
    parameter int unsigned DEPTH = v7u8_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  v7u8_pkg::v7u8_job_t   push_job,
    output logic                  full,
    input  logic                  pop,
    output v7u8_pkg::v7u8_job_t   head_job,
    output logic                  empty
);
    import v7u8_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    v7u8_job_t       mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full     = count_reg == FULL_CNT;
    assign empty    = count_reg == '0;
    assign head_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: sv/v7u8_back.sv
// Back end: expands one job into output words behind a registered output stage.
module v7u8_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  v7u8_pkg::v7u8_job_t   head_job,
    input  logic                  empty,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  has_byte,
    output logic                  run_end,
    output logic                  message_end,
    output v7u8_pkg::status_t     status
);
    import v7u8_pkg::*;

    logic [2:0]  idx_reg;
    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic        has_reg, run_end_reg, msg_end_reg;
    status_t     status_reg;

    logic [2:0]  len_a, n_data, n_total;
    logic        load, is_last, is_a, is_b;
    logic [7:0]  item_byte;

    always_comb
    begin
        len_a   = head_job.a_valid ? head_job.a_len : 3'd0;
        n_data  = len_a + {2'b00, head_job.b_valid};
        n_total = n_data + {2'b00, head_job.s_valid};
        is_a    = idx_reg < len_a;
        is_b    = !is_a && (idx_reg < n_data);
        is_last = idx_reg == (n_total - 3'd1);
        if (is_a)
            item_byte = head_job.a_bytes[idx_reg[1:0]];
        else if (is_b)
            item_byte = {1'b0, head_job.b_char};
        else
            item_byte = 8'h00;
    end

    assign load = !empty && (!valid_reg || out_ready);
    assign pop  = load && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= is_last ? 3'd0 : idx_reg + 3'd1;
            end
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg    <= item_byte;
            has_reg     <= is_a || is_b;
            run_end_reg <= is_last;
            msg_end_reg <= is_last && head_job.msg_end;
            status_reg  <= (is_a || is_b) ? ST_OK : head_job.s_code;
        end
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign has_byte    = has_reg;
    assign run_end     = run_end_reg;
    assign message_end = msg_end_reg;
    assign status      = status_reg;

endmodule

// File: sv/vlq7_to_utf8_transcoder.sv
// Top level of the VLQ-7 to UTF-8 transcoder: front end, job queue and back end.
//
// Usage: the input stream (s_*) carries one encoded byte per word, with s_tlast on
// the final byte of a message. Each code point arrives as a start byte (top bit 0)
// and seven-bit continuation bytes (top bit 1); bytes before the first start byte
// are skipped. The output stream (m_*) carries UTF-8 bytes and status-only words.
// m_tlast marks the word that closes a message: its status (m_tuser[2:1]) is zero
// on a clean end, or names the error; after an error the rest of that message is
// dropped, so the user discards the bytes already sent for it.
// An accepted word is written into the job queue and from there loaded into the
// output register, which raises m_tvalid for its first output word.
// Throughput: the front end takes one input word per cycle while the job queue
// has room; the back end sends one output word per cycle while the receiver is ready,
// so an input word with more than one output word (up to five) holds it until all are sent.
// The configuration channel (cfg_*) is always ready; the new byte limit is used
// from the next check on. Reset empties the queue and the output register,
// restores the limit to 65535 and clears all per-message state.
// A stalled receiver (m_tready low) holds the output word; the queue then fills
// and s_tready drops until the back end drains it.
module vlq7_to_utf8_transcoder #(
    parameter int unsigned QUEUE_DEPTH = v7u8_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration: output_byte_limit.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [v7u8_pkg::LIMIT_W-1:0]  cfg_data,
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] in_byte
    input  logic                          s_tlast,   // in_last
    // Output stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // [7:0] out_byte, [8] run_end, rest 0
    output logic [2:0]                    m_tuser,   // [0] has_byte, [2:1] status
    output logic                          m_tlast    // message_end
);
    import v7u8_pkg::*;

    v7u8_job_t  push_job, head_job;
    logic       push, pop, queue_full, queue_empty;
    logic [7:0] out_byte;
    logic       has_byte, run_end;
    status_t    status;

    v7u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    v7u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .head_job (head_job),
        .empty    (queue_empty)
    );

    v7u8_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_job    (head_job),
        .empty       (queue_empty),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .run_end     (run_end),
        .message_end (m_tlast),
        .status      (status)
    );

    assign m_tdata = {7'b0000000, run_end, out_byte};
    assign m_tuser = {status, has_byte};

endmodule

// File: bench/vlq7_to_utf8_transcoder_test.sv
// Self-checking testbench of the VLQ-7 to UTF-8 transcoder: directed table, random messages.
module vlq7_to_utf8_transcoder_test;

    import v7u8_pkg::*;

    // One output word as the bench sees it, split into its fields.
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       run_end;
        logic       msg_end;
        status_t    status;
    } utf8_word_t;

    // A row of the directed table either sends one input word or changes the byte limit.
    typedef enum logic {
        ROW_WORD,
        ROW_LIMIT
    } row_kind_t;

    // For a row with typed set, the expected output is written in the row itself:
    // either nothing (count 0) or one closing word (count 1, run_end and msg_end high).
    typedef struct packed {
        row_kind_t  kind;
        logic [15:0] value;
        logic       last;
        logic       typed;
        logic       count;
        logic [7:0] data;
        logic       has_byte;
        status_t    status;
    } plan_row_t;

    localparam int PLAN_ROWS = 28;

    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        // Continuation byte alone in a message: no start byte at all.
        '{ROW_WORD, 16'h0085, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, ST_NO_START},
        // Largest and smallest one-byte code points, each a message of its own.
        '{ROW_WORD, 16'h007F, 1'b1, 1'b1, 1'b1, 8'h7F, 1'b1, ST_OK},
        '{ROW_WORD, 16'h0000, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1, ST_OK},
        // Junk before the first start byte is skipped, then two ASCII characters.
        '{ROW_WORD, 16'h00FF, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK},
        '{ROW_WORD, 16'h0080, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK},
        '{ROW_WORD, 16'h0041, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK},
        '{ROW_WORD, 16'h0042, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
        // Smallest two-byte code point.
        '{ROW_WORD, 16'h0001, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK},
        '{ROW_WORD, 16'h0080, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
        // Largest code point, 0x10FFFF, reached without tripping the overflow check.
        '{ROW_WORD, 16'h0043, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK},
        '{ROW_WORD, 16'h00FF, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK},
        '{ROW_WORD, 16'h00FF, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
        // Overflow: a second continuation after the value passed 0x21FF, then the rest
        // of the message is dropped without any output.
        '{ROW_WORD, 16'h0044, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK},
        '{ROW_WORD, 16'h00FF, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK},
        '{ROW_WORD, 16'h0080, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, ST_INVALID},
        '{ROW_WORD, 16'h0041, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK},
        '{ROW_WORD, 16'h00FF, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK},
        // Lowest surrogate, 0xD800, closed by the end of the message.
        '{ROW_WORD, 16'h0003, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK},
        '{ROW_WORD, 16'h00B0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK},
        '{ROW_WORD, 16'h0080, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, ST_INVALID},
        // A limit of zero rejects even a single byte.
        '{ROW_LIMIT, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
        '{ROW_WORD, 16'h0041, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, ST_LIMIT},
        // A limit of three: one ASCII byte and one two-byte character fit, the next
        // character does not, so data words come before the closing status word.
        '{ROW_LIMIT, 16'h0003, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
        '{ROW_WORD, 16'h0041, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK},
        '{ROW_WORD, 16'h0001, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
        '{ROW_WORD, 16'h0080, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK},
        '{ROW_WORD, 16'h0042, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
        // Back to the widest limit before the random part.
        '{ROW_LIMIT, 16'hFFFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK}
    };

    // Code points at the edges of the UTF-8 length classes and of the surrogate range.
    localparam logic [20:0] BOUNDARY_CPS [12] = '{
        21'h000000, 21'h00007F, 21'h000080, 21'h0007FF, 21'h000800, 21'h00D7FF,
        21'h00D800, 21'h00DFFF, 21'h00E000, 21'h00FFFF, 21'h010000, 21'h10FFFF
    };

    // Cycles to let pass once nothing is owed, covering words in flight that
    // produce no output of their own.
    localparam int SETTLE_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;   // [7:0] out_byte, [8] run_end, rest 0
    logic [2:0]  m_tuser;   // [0] has_byte, [2:1] status
    logic        m_tlast;   // message_end

    // Predictor state: the bench's own copy of the per-message state and the limit.
    logic [20:0] cp_acc;
    logic        synced;
    logic        dropping;
    logic [16:0] byte_count;
    logic [15:0] byte_limit;

    // Words one input word produces, and every word the block still owes us.
    utf8_word_t  step_words[$];
    utf8_word_t  owed_words[$];

    // Idling percentages and the request for a long receiver hold-off. The sender
    // side writes these only at a rising edge; the receiver reads them at a falling one.
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned hold_req = 0;

    int unsigned words_sent = 0;
    int unsigned words_checked = 0;
    int unsigned msgs_closed = 0;
    int unsigned msgs_failed = 0;
    int unsigned fail_count = 0;

    vlq7_to_utf8_transcoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    // Run-away guard: far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("Timeout with %0d words still owed", owed_words.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic clear_message();
        cp_acc = '0;
        synced = 1'b0;
        dropping = 1'b0;
        byte_count = '0;
    endtask

    task automatic add_data(input logic [7:0] value);
        step_words.push_back('{value, 1'b1, 1'b0, 1'b0, ST_OK});
    endtask

    // Checks a finished code point and, if it is legal and fits under the limit,
    // appends its UTF-8 bytes. On failure nothing of it goes out.
    task automatic close_code_point(input logic [20:0] cp, output logic ok,
                                    output status_t st);
        int len;
        ok = 1'b0;
        st = ST_OK;
        if ((cp >= 21'h00D800 && cp <= 21'h00DFFF) || cp > 21'h10FFFF)
        begin
            st = ST_INVALID;
            return;
        end
        len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
        if (int'(byte_count) + len > int'(byte_limit))
        begin
            st = ST_LIMIT;
            return;
        end
        case (len)
            1:
            begin
                add_data(8'(cp));
            end
            2:
            begin
                add_data(8'h C0 | 8'((cp >> 6) & 21'h1F));
                add_data(8'h80 | 8'(cp & 21'h3F));
            end
            3:
            begin
                add_data(8'hE0 | 8'((cp >> 12) & 21'h0F));
                add_data(8'h80 | 8'((cp >> 6) & 21'h3F));
                add_data(8'h80 | 8'(cp & 21'h3F));
            end
            default:
            begin
                add_data(8'hF0 | 8'((cp >> 18) & 21'h07));
                add_data(8'h80 | 8'((cp >> 12) & 21'h3F));
                add_data(8'h80 | 8'((cp >> 6) & 21'h3F));
                add_data(8'h80 | 8'(cp & 21'h3F));
            end
        endcase
        byte_count = byte_count + 17'(len);
        ok = 1'b1;
    endtask

    // Works out the output words of one accepted input word into step_words.
    task automatic transcode_word(input logic [7:0] code, input logic last);
        logic    err;
        logic    ok;
        status_t st;
        step_words.delete();
        err = 1'b0;
        st = ST_OK;
        if (dropping)
        begin
            if (last)
                clear_message();
            return;
        end
        if (!synced)
        begin
            if (!code[7])
            begin
                synced = 1'b1;
                cp_acc = 21'(code);
            end
            else if (last)
            begin
                st = ST_NO_START;
                err = 1'b1;
            end
        end
        else if (!code[7])
        begin
            // A new start byte closes the pending code point.
            close_code_point(cp_acc, ok, st);
            if (ok)
                cp_acc = 21'(code);
            else
                err = 1'b1;
        end
        else if (cp_acc > 21'h0021FF)
        begin
            // Another seven bits would push the value past 0x10FFFF.
            st = ST_INVALID;
            err = 1'b1;
        end
        else
        begin
            cp_acc = {cp_acc[13:0], code[6:0]};
        end

        if (!err && last && synced)
        begin
            close_code_point(cp_acc, ok, st);
            if (!ok)
                err = 1'b1;
        end

        if (err)
        begin
            step_words.push_back('{8'h00, 1'b0, 1'b0, 1'b1, st});
            clear_message();
            if (!last)
                dropping = 1'b1;
        end
        else if (last)
        begin
            if (step_words.size() > 0)
                step_words[step_words.size() - 1].msg_end = 1'b1;
            clear_message();
        end
        if (step_words.size() > 0)
            step_words[step_words.size() - 1].run_end = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Output side: ready pattern and checker
    // ------------------------------------------------------------------

    // The receiver stalls at random, or for a long stretch when asked; the stretch
    // is counted here so that the sender keeps offering words meanwhile.
    always @(negedge clk)
    begin : rx_ready_gen
        int unsigned hold_left;
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Each accepted output word is compared with the oldest owed word.
    always @(posedge clk)
    begin : out_check
        utf8_word_t got;
        utf8_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[7:0], m_tuser[0], m_tdata[8], m_tlast, status_t'(m_tuser[2:1])};
            words_checked++;
            if (got.msg_end)
            begin
                msgs_closed++;
                if (got.status != ST_OK)
                    msgs_failed++;
            end
            if (owed_words.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected word: byte %h has %b run_end %b msg_end %b status %0d",
                         $time, got.data, got.has_byte, got.run_end, got.msg_end, got.status);
            end
            else
            begin
                want = owed_words.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    $display("%0t: mismatch: expected byte %h has %b run_end %b msg_end %b status %0d",
                             $time, want.data, want.has_byte, want.run_end, want.msg_end,
                             want.status);
                    $display("%0t:           actual byte %h has %b run_end %b msg_end %b status %0d",
                             $time, got.data, got.has_byte, got.run_end, got.msg_end, got.status);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offers one word, starting at a falling edge, and returns at the falling edge
    // after it is taken. tvalid stays high on return so that back-to-back words
    // never see it dropped and raised within one time step.
    task automatic push_word(input logic [7:0] code, input logic last, input logic typed,
                             input logic typed_count, input utf8_word_t typed_word);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= code;
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
        transcode_word(code, last);
        if (typed)
        begin
            if (typed_count)
                owed_words.push_back(typed_word);
        end
        else
        begin
            foreach (step_words[i])
                owed_words.push_back(step_words[i]);
        end
        @(negedge clk);
    endtask

    // Stops the sender and waits until every owed word has come out, plus the
    // block's latency for words that produce nothing. Called at a falling edge.
    task automatic await_quiet();
        s_tvalid <= 1'b0;
        while (owed_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Writes the byte limit; only called while the block is idle.
    task automatic write_limit(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        byte_limit = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Idling and hold-off knobs change at a rising edge, away from the ready generator.
    task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct,
                              input int unsigned hold_cycles);
        @(posedge clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        hold_req = hold_cycles;
        @(negedge clk);
    endtask

    function automatic logic [20:0] pick_code_point();
        logic [20:0] cp;
        case ($urandom_range(7))
            3:       cp = 21'($urandom_range(32'h80, 32'h7FF));
            4:       cp = 21'($urandom_range(32'h800, 32'hFFFF));
            5:       cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
            6:       cp = 21'($urandom_range(32'hD800, 32'hDFFF));
            7:       cp = BOUNDARY_CPS[$urandom_range(11)];
            default: cp = 21'($urandom_range(32'h7F));
        endcase
        return cp;
    endfunction

    // Sends one message: mostly well-formed code points in minimal VLQ-7 form, now
    // and then with junk in front, a stray extra continuation (which can overflow),
    // or no start byte at all.
    task automatic send_message();
        logic [7:0]  msg_bytes[$];
        logic [20:0] cp;
        int          groups;
        int          count;
        if ($urandom_range(19) == 0)
        begin
            count = $urandom_range(1, 3);
            repeat (count) msg_bytes.push_back(8'h80 | 8'($urandom_range(127)));
        end
        else
        begin
            if ($urandom_range(7) == 0)
                msg_bytes.push_back(8'h80 | 8'($urandom_range(127)));
            count = $urandom_range(1, 4);
            repeat (count)
            begin
                cp = pick_code_point();
                groups = (cp < 21'h80) ? 1 : (cp < 21'h4000) ? 2 : 3;
                msg_bytes.push_back(8'((cp >> (7 * (groups - 1))) & 21'h7F));
                for (int g = groups - 2; g >= 0; g--)
                    msg_bytes.push_back(8'h80 | 8'((cp >> (7 * g)) & 21'h7F));
                if ($urandom_range(15) == 0)
                    msg_bytes.push_back(8'h80 | 8'($urandom_range(127)));
            end
        end
        foreach (msg_bytes[i])
            push_word(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin : test_seq
        utf8_word_t  row_word;
        int unsigned target;
        logic [15:0] limit_value;

        byte_limit = 16'hFFFF;
        clear_message();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, under the first idling pattern.
        set_idling(22, 82, 0);
        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (PLAN[r].kind == ROW_LIMIT)
            begin
                await_quiet();
                write_limit(PLAN[r].value);
            end
            else
            begin
                row_word = '{PLAN[r].data, PLAN[r].has_byte, 1'b1, 1'b1, PLAN[r].status};
                push_word(PLAN[r].value[7:0], PLAN[r].last, PLAN[r].typed, PLAN[r].count,
                          row_word);
            end
        end

        // Random part: three idling patterns, each with two byte-limit settings.
        // Every limit change waits for the block to drain first.
        for (int p = 0; p < 3; p++)
        begin
            for (int s = 0; s < 2; s++)
            begin
                await_quiet();
                case (p * 2 + s)
                    0:       limit_value = 16'($urandom_range(4, 24));
                    1:       limit_value = 16'hFFFF;
                    2:       limit_value = 16'd1;
                    3:       limit_value = 16'($urandom_range(25, 200));
                    4:       limit_value = 16'hFFFF;
                    default: limit_value = 16'($urandom_range(6, 40));
                endcase
                write_limit(limit_value);
                if (p == 1 && s == 0)
                    set_idling(82, 22, 0);
                else if (p == 2 && s == 0)
                    set_idling(0, 0, 300);  // long receiver stall fills the block
                target = words_sent + 50;
                while (words_sent < target)
                begin
                    if ($urandom_range(9) == 0)
                        push_word(8'($urandom), $urandom_range(3) == 0, 1'b0, 1'b0, '0);
                    else
                        send_message();
                end
            end
        end

        await_quiet();

        $display("Sent %0d input words and checked %0d output words over %0d messages,",
                 words_sent, words_checked, msgs_closed);
        $display("%0d of them closed with an error status, with byte limits from 0 to 65535.",
                 msgs_failed);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
sv/v7u8_pkg.sv
sv/v7u8_front.sv
sv/v7u8_queue.sv
sv/v7u8_back.sv
sv/vlq7_to_utf8_transcoder.sv
bench/vlq7_to_utf8_transcoder_test.sv
